### rtl/core/hrpt_pkg.sv
// Shared types, constants and table functions for the hopping receive packet tracker.
// No dependencies; used by every module under rtl/core.
package hrpt_pkg;

    localparam int HOP_CHANNELS  = 9;
    localparam int DWELL_PACKETS = 16;
    localparam int HOP_TABLE_LEN = 9;
    localparam int SCAN_W        = 4;

    localparam logic [7:0]  PROTO_LEN = 8'd12;
    localparam logic [7:0]  PLAIN_LEN = 8'd4;
    localparam logic [7:0]  PKT_TYPE  = 8'h01;
    localparam logic [7:0]  PKT_EPOCH = 8'h00;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [3:0]  POS_MAX   = 4'd15;
    localparam logic [3:0]  MISS_MAX  = 4'd15;

    localparam logic [5:0] FIXED_CHANNEL_RST = 6'd16;
    localparam logic [7:0] MAGIC_RST         = 8'hA7;
    localparam logic [7:0] SESSION_RST       = 8'h21;
    localparam logic [3:0] MISS_LIMIT_RST    = 4'd8;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_CRC_ERR = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_LENGTH  = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_SESSION = 3'd3,
        ST_BAD_CRC     = 3'd4,
        ST_RADIO_CRC   = 3'd5,
        ST_TIMEOUT     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CFG_PROTOCOL_MODE = 3'd0,
        CFG_HOP_ENABLE    = 3'd1,
        CFG_FIXED_CHANNEL = 3'd2,
        CFG_MAGIC_BYTE    = 3'd3,
        CFG_SESSION_CODE  = 3'd4,
        CFG_MISS_LIMIT    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic       protocol_mode;
        logic       hop_enable;
        logic [5:0] fixed_channel;
        logic [7:0] magic_byte;
        logic [7:0] session_code;
        logic [3:0] fast_miss_limit;
    } t_cfg;

    // assembler -> tracker / top
    typedef struct packed {
        logic       result;
        t_status    status;
        logic [7:0] seq;
    } t_verdict;

    // tracker -> result register
    typedef struct packed {
        logic [5:0] next_channel;
        logic [7:0] gap_added;
        logic       duplicate;
        logic       reacquire;
        logic [7:0] expected_next;
    } t_track;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // hop index of a sequence number, as a constant lookup
    function automatic logic [SCAN_W-1:0] hop_index(input logic [7:0] s);
        logic [SCAN_W-1:0] r;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            if (s == 8'(i)) r = SCAN_W'((i / DWELL_PACKETS) % HOP_CHANNELS);
        end
        return r;
    endfunction

    function automatic logic [5:0] hop_channel(input logic [SCAN_W-1:0] idx);
        logic [5:0] ch;
        ch = '0;
        for (int i = 0; i < (1 << SCAN_W); i++) begin
            if (idx == SCAN_W'(i)) ch = 6'(4 * (1 + (i % HOP_TABLE_LEN)));
        end
        return ch;
    endfunction

endpackage

### rtl/core/hrpt_assembler.sv
// Packet byte assembly: length, header checks, CRC-16 and packet verdict.
// Depends on hrpt_pkg.
module hrpt_assembler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hrpt_pkg::t_cfg    i_cfg,
    input  logic              i_fire,
    input  hrpt_pkg::t_kind   i_kind,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output hrpt_pkg::t_verdict o_verdict
);

    logic [3:0]  r_pos,   n_pos;
    logic [7:0]  r_len,   n_len;
    logic [15:0] r_crc,   n_crc;
    logic [1:0]  r_flags, n_flags;
    logic [7:0]  r_seq,   n_seq;
    logic [15:0] r_rcrc,  n_rcrc;
    logic [3:0]  p;
    logic [3:0]  count;
    logic [7:0]  want;
    logic        len_bad;

    always_comb begin
        n_len   = r_len;
        n_crc   = r_crc;
        n_flags = r_flags;
        n_seq   = r_seq;
        n_rcrc  = r_rcrc;
        p       = r_pos - 4'd1;
        if (r_pos == 4'd0) begin
            n_len = i_byte;
        end else begin
            if (p < 4'd10) n_crc = hrpt_pkg::crc_byte(r_crc, i_byte);
            if ((p == 4'd0 && i_byte != i_cfg.magic_byte) ||
                (p == 4'd1 && i_byte != hrpt_pkg::PKT_TYPE)) n_flags[0] = 1'b1;
            if ((p == 4'd2 && i_byte != i_cfg.session_code) ||
                (p == 4'd4 && i_byte != hrpt_pkg::PKT_EPOCH)) n_flags[1] = 1'b1;
            if (p == 4'd3) n_seq = i_byte;
            if (p == 4'd10) n_rcrc[7:0] = i_byte;
            if (p == 4'd11) n_rcrc[15:8] = i_byte;
        end
        n_pos = (r_pos != hrpt_pkg::POS_MAX) ? r_pos + 4'd1 : r_pos;
        count = n_pos - 4'd1;
        want  = i_cfg.protocol_mode ? hrpt_pkg::PROTO_LEN : hrpt_pkg::PLAIN_LEN;
        len_bad = (n_len != want) || ({4'd0, count} != want);
    end

    always_comb begin
        o_verdict.seq    = n_seq;
        o_verdict.result = (i_kind == hrpt_pkg::KIND_BYTE && i_last) ||
                           i_kind == hrpt_pkg::KIND_CRC_ERR ||
                           i_kind == hrpt_pkg::KIND_TIMEOUT;
        priority if (i_kind == hrpt_pkg::KIND_CRC_ERR)
            o_verdict.status = hrpt_pkg::ST_RADIO_CRC;
        else if (i_kind == hrpt_pkg::KIND_TIMEOUT)
            o_verdict.status = hrpt_pkg::ST_TIMEOUT;
        else if (len_bad)
            o_verdict.status = hrpt_pkg::ST_BAD_LENGTH;
        else if (i_cfg.protocol_mode && n_flags[0])
            o_verdict.status = hrpt_pkg::ST_BAD_MAGIC;
        else if (i_cfg.protocol_mode && n_flags[1])
            o_verdict.status = hrpt_pkg::ST_BAD_SESSION;
        else if (i_cfg.protocol_mode && n_rcrc != n_crc)
            o_verdict.status = hrpt_pkg::ST_BAD_CRC;
        else
            o_verdict.status = hrpt_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_crc   <= hrpt_pkg::CRC_INIT;
            r_flags <= '0;
            r_seq   <= '0;
            r_rcrc  <= '0;
        end else if (i_fire) begin
            unique case (i_kind)
                hrpt_pkg::KIND_BYTE: begin
                    if (i_last) begin
                        r_pos   <= '0;
                        r_len   <= '0;
                        r_crc   <= hrpt_pkg::CRC_INIT;
                        r_flags <= '0;
                        r_seq   <= '0;
                        r_rcrc  <= '0;
                    end else begin
                        r_pos   <= n_pos;
                        r_len   <= n_len;
                        r_crc   <= n_crc;
                        r_flags <= n_flags;
                        r_seq   <= n_seq;
                        r_rcrc  <= n_rcrc;
                    end
                end
                hrpt_pkg::KIND_CRC_ERR, hrpt_pkg::KIND_TIMEOUT: begin
                    r_pos   <= '0;
                    r_len   <= '0;
                    r_crc   <= hrpt_pkg::CRC_INIT;
                    r_flags <= '0;
                    r_seq   <= '0;
                    r_rcrc  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/core/hrpt_tracker.sv
// Sequence tracking, miss counting and hop channel selection.
// Depends on hrpt_pkg.
module hrpt_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrpt_pkg::t_cfg     i_cfg,
    input  logic               i_fire,
    input  hrpt_pkg::t_verdict i_verdict,
    output hrpt_pkg::t_track   o_track
);

    localparam int SW = hrpt_pkg::SCAN_W;

    logic [7:0]    r_expected, n_expected;
    logic          r_seen,     n_seen;
    logic [3:0]    r_miss,     n_miss;
    logic [SW-1:0] r_scan,     n_scan;
    logic [7:0]    delta;
    logic [7:0]    exp_inc;
    logic [SW:0]   scan_inc;
    logic [7:0]    gap;
    logic          dup;
    logic          rq;

    always_comb begin
        n_expected = r_expected;
        n_seen     = r_seen;
        n_miss     = r_miss;
        n_scan     = r_scan;
        gap        = '0;
        dup        = 1'b0;
        rq         = 1'b0;
        delta      = i_verdict.seq - r_expected;
        exp_inc    = r_expected + 8'd1;
        scan_inc   = {1'b0, r_scan} + (SW+1)'(1);
        if (i_verdict.status == hrpt_pkg::ST_OK) begin
            n_seen = 1'b1;
            if (r_seen) begin
                if (delta == 8'hFF) dup = 1'b1;
                else                gap = delta;
            end
            n_expected = i_verdict.seq + 8'd1;
            n_miss     = '0;
            n_scan     = i_cfg.hop_enable ? hrpt_pkg::hop_index(n_expected) : '0;
        end else if (i_cfg.hop_enable) begin
            n_miss = (r_miss != hrpt_pkg::MISS_MAX) ? r_miss + 4'd1 : r_miss;
            if (r_seen && n_miss <= i_cfg.fast_miss_limit) begin
                n_expected = exp_inc;
                n_scan     = hrpt_pkg::hop_index(exp_inc);
            end else begin
                n_scan = (scan_inc >= (SW+1)'(hrpt_pkg::HOP_CHANNELS)) ? '0 : scan_inc[SW-1:0];
                rq     = n_miss > i_cfg.fast_miss_limit;
            end
        end
        o_track.next_channel  = i_cfg.hop_enable ? hrpt_pkg::hop_channel(n_scan)
                                                 : i_cfg.fixed_channel;
        o_track.gap_added     = gap;
        o_track.duplicate     = dup;
        o_track.reacquire     = rq;
        o_track.expected_next = n_expected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
            r_seen     <= 1'b0;
            r_miss     <= '0;
            r_scan     <= '0;
        end else if (i_fire) begin
            r_expected <= n_expected;
            r_seen     <= n_seen;
            r_miss     <= n_miss;
            r_scan     <= n_scan;
        end
    end

endmodule

### rtl/core/hopping_rx_packet_tracker.sv
// Top level of the hopping receive packet tracker: input register, result register, config.
// Depends on hrpt_pkg, hrpt_assembler and hrpt_tracker.
//
// One item is accepted per clock while the input side is not stalled. Each item is held
// in the input register while the assembler and tracker update their state, and any result
// it causes is loaded into the result register as the item leaves the input register.
// A result is produced for the final byte of a packet and for each radio CRC-error or
// timeout item; other bytes and the unused kind produce none. The input side stalls only
// while a result is waiting in the result register and a further result is ready behind it.
module hopping_rx_packet_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [5:0] next_channel, [13:6] gap_added, [14] duplicate, [15] reacquire,
    // [23:16] expected_next
    output logic [23:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser    // [2:0] status
);

    hrpt_pkg::t_cfg     r_cfg;
    logic               r_in_valid;
    hrpt_pkg::t_kind    r_in_kind;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    hrpt_pkg::t_status  r_out_status;
    hrpt_pkg::t_track   r_out_track;
    hrpt_pkg::t_verdict verdict;
    hrpt_pkg::t_track   track;
    logic               out_free;
    logic               advance;
    logic               s_ready;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign advance  = r_in_valid && (!verdict.result || out_free);
    assign s_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protocol_mode   <= 1'b0;
            r_cfg.hop_enable      <= 1'b0;
            r_cfg.fixed_channel   <= hrpt_pkg::FIXED_CHANNEL_RST;
            r_cfg.magic_byte      <= hrpt_pkg::MAGIC_RST;
            r_cfg.session_code    <= hrpt_pkg::SESSION_RST;
            r_cfg.fast_miss_limit <= hrpt_pkg::MISS_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hrpt_pkg::CFG_PROTOCOL_MODE: r_cfg.protocol_mode   <= i_cfg_data[0];
                hrpt_pkg::CFG_HOP_ENABLE:    r_cfg.hop_enable      <= i_cfg_data[0];
                hrpt_pkg::CFG_FIXED_CHANNEL: r_cfg.fixed_channel   <= i_cfg_data[5:0];
                hrpt_pkg::CFG_MAGIC_BYTE:    r_cfg.magic_byte      <= i_cfg_data;
                hrpt_pkg::CFG_SESSION_CODE:  r_cfg.session_code    <= i_cfg_data;
                hrpt_pkg::CFG_MISS_LIMIT:    r_cfg.fast_miss_limit <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_axis_tvalid) begin
            r_in_kind <= hrpt_pkg::t_kind'(i_s_axis_tuser);
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    hrpt_assembler u_assembler (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_fire    (advance),
        .i_kind    (r_in_kind),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_verdict (verdict)
    );

    hrpt_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_fire    (advance && verdict.result),
        .i_verdict (verdict),
        .o_track   (track)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && verdict.result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && verdict.result) begin
            r_out_status <= verdict.status;
            r_out_track  <= track;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {r_out_track.expected_next, r_out_track.reacquire,
                              r_out_track.duplicate, r_out_track.gap_added,
                              r_out_track.next_channel};

endmodule

### rtl/core/hrpt_checker.sv
// Port-level checks for the hopping receive packet tracker, bound to the top level.
// Depends on hrpt_pkg and hopping_rx_packet_tracker.
module hrpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    // a stalled result holds its item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // input side only stalls behind a blocked result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a blocked result");

    // failures never report gap or duplicate
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != hrpt_pkg::ST_OK |-> o_m_axis_tdata[14:6] == 9'd0)
        else $error("gap or duplicate on a failure");

    // a good packet never asks for reacquire
    a_ok_no_reacq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == hrpt_pkg::ST_OK |-> !o_m_axis_tdata[15])
        else $error("reacquire on a good packet");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind hopping_rx_packet_tracker hrpt_checker u_hrpt_checker (.*);

### test/tb.sv
// Self-checking bench for hopping_rx_packet_tracker: queued byte and event items go in,
// each verdict coming out is checked against a local model of the tracker.
// Depends on hrpt_pkg and the RTL under rtl/core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrpt_pkg::*;

    localparam int STUCK_LIMIT = 3000;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_rx_item;

    typedef struct packed {
        t_status    status;
        logic [5:0] chan;
        logic [7:0] gap;
        logic       dup;
        logic       reacq;
        logic [7:0] nxt;
    } t_verdict_exp;

    typedef enum int {
        FLT_NONE, FLT_LENGTH, FLT_SHORT, FLT_LONG, FLT_PAYLOAD,
        FLT_MAGIC, FLT_TYPE, FLT_SESSION, FLT_EPOCH, FLT_CRC
    } t_fault;

    typedef enum int { RX_FREE, RX_RANDOM, RX_PERIODIC, RX_CHOKED } t_stall;

    typedef logic [7:0] t_bytes[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // [7:0] rx_byte
    logic [1:0]  i_s_axis_tuser = '0;   // [1:0] kind
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [5:0] next_channel, [13:6] gap_added, [14] duplicate, [15] reacquire,
    // [23:16] expected_next
    logic [23:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;        // [2:0] status

    hopping_rx_packet_tracker DUT (.*);

    always #5 i_clk = ~i_clk;

    // model state: registers, sequence tracking and packet assembly
    logic        c_proto = 1'b0;
    logic        c_hop = 1'b0;
    logic [5:0]  c_fixed = FIXED_CHANNEL_RST;
    logic [7:0]  c_magic = MAGIC_RST;
    logic [7:0]  c_session = SESSION_RST;
    logic [3:0]  c_limit = MISS_LIMIT_RST;
    logic [7:0]  t_expected = '0;
    logic        t_seen = 1'b0;
    logic [3:0]  t_miss = '0;
    logic [3:0]  t_scan = '0;
    logic [3:0]  a_pos = '0;
    logic [7:0]  a_len = '0;
    logic [15:0] a_crc = CRC_INIT;
    logic [1:0]  a_flags = '0;
    logic [7:0]  a_seq = '0;
    logic [15:0] a_rcrc = '0;

    t_rx_item     rx_items_q[$];
    t_verdict_exp verdict_q[$];
    t_verdict_exp got_verdict;
    int           n_queued = 0;
    int           err_count = 0;
    logic [7:0]   tx_seq = '0;
    int           burst_left = 0;
    int           gap_left = 0;
    t_stall       rx_mode = RX_FREE;
    int           rx_left = 0;
    int           rx_tick = 0;
    int           stuck_cycles = 0;

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic logic [3:0] seq_hop(logic [7:0] s);
        return 4'((int'(s) / DWELL_PACKETS) % HOP_CHANNELS);
    endfunction

    function automatic logic [5:0] tuned_channel();
        return c_hop ? 6'(4 * (1 + int'(t_scan) % HOP_CHANNELS)) : c_fixed;
    endfunction

    function automatic void clear_assembly();
        a_pos = '0;
        a_len = '0;
        a_crc = CRC_INIT;
        a_flags = '0;
        a_seq = '0;
        a_rcrc = '0;
    endfunction

    // failed reception: predictive advance or reacquire scan; returns reacquire flag
    function automatic logic count_miss();
        if (!c_hop) return 1'b0;
        if (t_miss < MISS_MAX) t_miss++;
        if (t_seen && t_miss <= c_limit) begin
            t_expected = t_expected + 8'd1;
            t_scan = seq_hop(t_expected);
            return 1'b0;
        end
        t_scan = (int'(t_scan) + 1 >= HOP_CHANNELS) ? 4'd0 : t_scan + 4'd1;
        return t_miss > c_limit;
    endfunction

    function automatic void post_verdict(t_status st, logic [7:0] gap, logic dup, logic rq);
        t_verdict_exp v;
        v.status = st;
        v.chan = tuned_channel();
        v.gap = gap;
        v.dup = dup;
        v.reacq = rq;
        v.nxt = t_expected;
        verdict_q.push_back(v);
    endfunction

    function automatic void judge_rx_item(t_rx_item it);
        int         pos;
        int         p;
        int         want;
        t_status    st;
        logic [7:0] delta;
        logic [7:0] gap;
        logic       dup;
        logic       rq;
        if (it.kind == KIND_UNUSED) return;
        if (it.kind != KIND_BYTE) begin
            clear_assembly();
            rq = count_miss();
            post_verdict(it.kind == KIND_CRC_ERR ? ST_RADIO_CRC : ST_TIMEOUT, 8'd0, 1'b0, rq);
            return;
        end
        pos = int'(a_pos);
        if (pos == 0) begin
            a_len = it.data;
        end else begin
            p = pos - 1;
            if (p < 10) a_crc = crc16_step(a_crc, it.data);
            if ((p == 0 && it.data != c_magic) || (p == 1 && it.data != PKT_TYPE))
                a_flags[0] = 1'b1;
            if ((p == 2 && it.data != c_session) || (p == 4 && it.data != PKT_EPOCH))
                a_flags[1] = 1'b1;
            if (p == 3) a_seq = it.data;
            if (p == 10) a_rcrc[7:0] = it.data;
            if (p == 11) a_rcrc[15:8] = it.data;
        end
        if (pos < int'(POS_MAX)) pos++;
        a_pos = 4'(pos);
        if (!it.last) return;
        want = c_proto ? int'(PROTO_LEN) : int'(PLAIN_LEN);
        if (int'(a_len) != want || pos - 1 != want) st = ST_BAD_LENGTH;
        else if (c_proto && a_flags[0]) st = ST_BAD_MAGIC;
        else if (c_proto && a_flags[1]) st = ST_BAD_SESSION;
        else if (c_proto && a_rcrc != a_crc) st = ST_BAD_CRC;
        else st = ST_OK;
        if (st != ST_OK) begin
            clear_assembly();
            rq = count_miss();
            post_verdict(st, 8'd0, 1'b0, rq);
            return;
        end
        gap = '0;
        dup = 1'b0;
        if (!t_seen) begin
            t_seen = 1'b1;
        end else begin
            delta = a_seq - t_expected;
            if (delta == 8'hFF) dup = 1'b1;
            else gap = delta;
        end
        t_expected = a_seq + 8'd1;
        t_miss = '0;
        t_scan = c_hop ? seq_hop(t_expected) : 4'd0;
        clear_assembly();
        post_verdict(ST_OK, gap, dup, 1'b0);
    endfunction

    function automatic void note_err(string msg);
        err_count++;
        if (err_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic void cmp_field(string name, int unsigned e, int unsigned a);
        if (e != a) note_err($sformatf("%s expected %0d, got %0d", name, e, a));
    endfunction

    // mostly in order, with duplicates, gaps and random jumps
    function automatic logic [7:0] pick_seq();
        int         r;
        logic [7:0] s;
        r = $urandom_range(0, 99);
        if (r < 70) s = tx_seq;
        else if (r < 80) s = tx_seq - 8'd2;
        else if (r < 90) s = tx_seq + 8'($urandom_range(1, 254));
        else if (r < 95) s = tx_seq + 8'd254;
        else s = 8'($urandom);
        tx_seq = s + 8'd1;
        return s;
    endfunction

    // byte 0 is the length, payload byte k sits at index k + 1
    function automatic t_bytes make_packet(logic proto, t_fault f);
        t_bytes      pk;
        logic [15:0] c;
        int          k;
        c = CRC_INIT;
        if (proto) begin
            pk.push_back(PROTO_LEN);
            pk.push_back(c_magic);
            pk.push_back(PKT_TYPE);
            pk.push_back(c_session);
            pk.push_back(pick_seq());
            pk.push_back(PKT_EPOCH);
            repeat (5) pk.push_back(8'($urandom));
            for (k = 1; k <= 10; k++) c = crc16_step(c, pk[k]);
            pk.push_back(c[7:0]);
            pk.push_back(c[15:8]);
        end else begin
            pk.push_back(PLAIN_LEN);
            repeat (3) pk.push_back(8'($urandom));
            pk.push_back(pick_seq());
        end
        case (f)
            FLT_LENGTH:  pk[0] = pk[0] ^ 8'($urandom_range(1, 255));
            FLT_SHORT: begin
                k = $urandom_range(1, pk.size() - 1);
                repeat (k) void'(pk.pop_back());
            end
            FLT_LONG:    repeat ($urandom_range(1, 8)) pk.push_back(8'($urandom));
            FLT_PAYLOAD: pk[$urandom_range(1, pk.size() - 1)] = 8'($urandom);
            FLT_MAGIC:   pk[1] = pk[1] ^ 8'($urandom_range(1, 255));
            FLT_TYPE:    pk[2] = pk[2] ^ 8'($urandom_range(1, 255));
            FLT_SESSION: pk[3] = pk[3] ^ 8'($urandom_range(1, 255));
            FLT_EPOCH:   pk[5] = pk[5] ^ 8'($urandom_range(1, 255));
            FLT_CRC:     pk[$urandom_range(11, 12)] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
        return pk;
    endfunction

    task automatic add(t_kind k, logic [7:0] b, logic l);
        t_rx_item it;
        it.kind = k;
        it.data = b;
        it.last = l;
        rx_items_q.push_back(it);
        if (k != KIND_UNUSED) n_queued++;
    endtask

    // cut >= 0 puts a CRC-error, timeout or unused-kind item in front of that byte
    task automatic send_packet(t_bytes pk, int cut);
        int i;
        for (i = 0; i < pk.size(); i++) begin
            if (i == cut)
                add(t_kind'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
            add(KIND_BYTE, pk[i], i == pk.size() - 1);
        end
    endtask

    task automatic gen(int n);
        int     stop_at;
        int     r;
        t_bytes pk;
        stop_at = n_queued + n;
        while (n_queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_packet(make_packet(c_proto, FLT_NONE), -1);
            end else if (r < 72) begin
                send_packet(make_packet(c_proto, t_fault'(c_proto ? $urandom_range(1, 9)
                                                                   : $urandom_range(1, 4))), -1);
            end else if (r < 78) begin
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(12, 20)
                                                    : $urandom_range(1, 3))
                    add($urandom_range(0, 1) ? KIND_CRC_ERR : KIND_TIMEOUT,
                        8'($urandom), 1'($urandom));
            end else if (r < 85) begin
                pk = make_packet(c_proto, FLT_NONE);
                send_packet(pk, $urandom_range(0, pk.size() - 1));
            end else if (r < 90) begin
                send_packet(make_packet(!c_proto, FLT_NONE), -1);
            end else begin
                repeat ($urandom_range(1, 6))
                    add(t_kind'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (rx_items_q.size() != 0 || i_s_axis_tvalid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PROTOCOL_MODE: c_proto = val[0];
            CFG_HOP_ENABLE:    c_hop = val[0];
            CFG_FIXED_CHANNEL: c_fixed = val[5:0];
            CFG_MAGIC_BYTE:    c_magic = val;
            CFG_SESSION_CODE:  c_session = val;
            CFG_MISS_LIMIT:    c_limit = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [7:0] proto, logic [7:0] hop, logic [7:0] fixed,
                             logic [7:0] magic, logic [7:0] session, logic [7:0] limit);
        set_reg(CFG_PROTOCOL_MODE, proto);
        set_reg(CFG_HOP_ENABLE, hop);
        set_reg(CFG_FIXED_CHANNEL, fixed);
        set_reg(CFG_MAGIC_BYTE, magic);
        set_reg(CFG_SESSION_CODE, session);
        set_reg(CFG_MISS_LIMIT, limit);
    endtask

    task automatic run_phase(int n);
        gen(n / 2);
        drain();
        gen(n - n / 2);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain packets, fixed channel
        add(KIND_BYTE, PLAIN_LEN, 1'b0);
        add(KIND_BYTE, 8'h00, 1'b0);
        add(KIND_BYTE, 8'hFF, 1'b0);
        add(KIND_BYTE, 8'h55, 1'b0);
        add(KIND_BYTE, 8'hFF, 1'b1);
        add(KIND_UNUSED, 8'hFF, 1'b1);
        add(KIND_CRC_ERR, 8'h00, 1'b0);
        add(KIND_TIMEOUT, 8'hAA, 1'b1);
        add(KIND_BYTE, PLAIN_LEN, 1'b0);
        add(KIND_BYTE, 8'h01, 1'b0);
        add(KIND_BYTE, 8'h02, 1'b1);
        drain();

        configure(8'd1, 8'd1, 8'd16, MAGIC_RST, SESSION_RST, 8'd8);
        send_packet(make_packet(1'b1, FLT_NONE), -1);
        run_phase(230);

        configure(8'd1, 8'd1, 8'd39, 8'h00, 8'hFF, 8'd0);
        run_phase(230);
        configure(8'd1, 8'd0, 8'd0, 8'hFF, 8'h00, 8'd15);
        run_phase(230);
        configure(8'd0, 8'd0, 8'd63, MAGIC_RST, SESSION_RST, 8'd15);
        run_phase(230);
        configure(8'd0, 8'd1, 8'd7, 8'h5A, 8'hC3, 8'd3);
        run_phase(230);
        repeat (3) begin
            configure(8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
            run_phase(180);
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                judge_rx_item(rx_items_q[0]);
                void'(rx_items_q.pop_front());
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // hold the item until taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (rx_items_q.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser <= rx_items_q[0].kind;
                i_s_axis_tdata <= rx_items_q[0].data;
                i_s_axis_tlast <= rx_items_q[0].last;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall pattern, chosen anew after a random hold time
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_stall'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_FREE:     i_m_axis_tready <= 1'b1;
            RX_RANDOM:   i_m_axis_tready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: i_m_axis_tready <= (rx_tick % 12 >= 5);
            default:     i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                note_err("result with no verdict pending");
            end else begin
                got_verdict = verdict_q.pop_front();
                cmp_field("status", got_verdict.status, o_m_axis_tuser);
                cmp_field("next_channel", got_verdict.chan, o_m_axis_tdata[5:0]);
                cmp_field("gap_added", got_verdict.gap, o_m_axis_tdata[13:6]);
                cmp_field("duplicate", got_verdict.dup, o_m_axis_tdata[14]);
                cmp_field("reacquire", got_verdict.reacq, o_m_axis_tdata[15]);
                cmp_field("expected_next", got_verdict.nxt, o_m_axis_tdata[23:16]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (rx_items_q.size() == 0 && verdict_q.size() == 0)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[%0t] watchdog: no progress, %0d verdicts outstanding",
                     $time, verdict_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

### filelist.f
rtl/core/hrpt_pkg.sv
rtl/core/hrpt_assembler.sv
rtl/core/hrpt_tracker.sv
rtl/core/hopping_rx_packet_tracker.sv
rtl/core/hrpt_checker.sv
test/tb.sv
